/* src/gpj_pkg.sv */
// Package for the Gaussian peak block: widths, register indexes, shared types and the
// functions that build the exponential table and saturate results.
// No dependencies.
`timescale 1ns / 1ps
package gpj_pkg;

   localparam int EXP_TABLE_BITS_DEF = 8;
   localparam int DATA_W = 32;
   localparam int EXP_W = 17;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_SIGMA = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MODE = 2'd3;

   localparam logic [DATA_W-1:0] INV_SIGMA_RESET = 32'h0100_0000;

   typedef struct packed {
      logic valid;
      logic last;
      logic dneg;
   } meta_type;

   function automatic logic [63:0] div_small(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      q = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [EXP_W-1:0] exp_entry(input int k, input int bits);
      longint unsigned y;
      longint unsigned z;
      longint unsigned term;
      longint unsigned v;
      longint sum;
      longint unsigned r;
      y = (longint'(k) << 34) >> bits;
      z = y >> 5;
      term = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int n = 1; n <= 16; n++) begin
         term = div_small((term * z) >> 30, 64'(n));
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      v = (sum > 0) ? longint'(sum) : 64'd0;
      for (int s = 0; s < 5; s++) begin
         v = (v * v + (64'd1 << 29)) >> 30;
      end
      r = (v + (64'd1 << 13)) >> 14;
      return r[EXP_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] sat_mag(input logic [63:0] mag, input logic neg);
      logic [63:0] m;
      if (neg) begin
         m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
         return 32'd0 - m[DATA_W-1:0];
      end else begin
         m = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
         return m[DATA_W-1:0];
      end
   endfunction

endpackage

/* src/gaussian_peak_with_jacobian.sv */
// Gaussian peak with its Jacobian: one result beat for each sample beat taken. busy stays
// low, so a sample may be started in every cycle; each sample passes through a chain of
// pipelined wide multipliers that forms |d|*inv_sigma, its square, height*e and the
// derivative products. Results cannot be held off: each appears for one cycle with
// rsp_valid. Depends on gpj_pkg, gpj_mul, gpj_exp.
`timescale 1ns / 1ps
module gaussian_peak_with_jacobian
   import gpj_pkg::*;
#(
   parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [DATA_W-1:0]    req_x_sample,
   input  logic                 req_last_in,
   output logic                 rsp_valid,
   output logic [DATA_W-1:0]    rsp_peak_value,
   output logic [DATA_W-1:0]    rsp_d_height,
   output logic [DATA_W-1:0]    rsp_d_centre,
   output logic [DATA_W-1:0]    rsp_d_width,
   output logic                 rsp_last_out,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   logic [DATA_W-1:0] height_ff, centre_ff, inv_ff;
   logic mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= '0;
         centre_ff <= '0;
         inv_ff <= INV_SIGMA_RESET;
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_HEIGHT: height_ff <= csr_wdata;
            REG_CENTRE: centre_ff <= csr_wdata;
            REG_INV_SIGMA: inv_ff <= csr_wdata;
            REG_MODE: mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic hneg;
   logic [DATA_W-1:0] hm;
   assign hneg = height_ff[DATA_W-1];
   assign hm = hneg ? (~height_ff + 1'b1) : height_ff;

   logic [DATA_W:0] d;
   logic [DATA_W:0] dabs;
   assign d = {req_x_sample[DATA_W-1], req_x_sample} - {centre_ff[DATA_W-1], centre_ff};
   assign dabs = d[DATA_W] ? (~d + 1'b1) : d;

   meta_type meta_ff [13];
   logic [DATA_W-1:0] dm_ff;

   always_ff @(posedge clock) begin
      meta_ff[0].last <= req_last_in;
      meta_ff[0].dneg <= d[DATA_W];
      for (int k = 1; k < 13; k++) begin
         meta_ff[k].last <= meta_ff[k-1].last;
         meta_ff[k].dneg <= meta_ff[k-1].dneg;
      end
      dm_ff <= dabs[DATA_W-1:0];
      if (reset) begin
         for (int k = 0; k < 13; k++) begin
            meta_ff[k].valid <= 1'b0;
         end
      end else begin
         meta_ff[0].valid <= start;
         for (int k = 1; k < 13; k++) begin
            meta_ff[k].valid <= meta_ff[k-1].valid;
         end
      end
   end

   logic [127:0] t_p, dd_p;
   gpj_mul u_mul_t (.clock(clock), .a({32'd0, dm_ff}), .b({32'd0, inv_ff}), .p(t_p));
   gpj_mul u_mul_dd (.clock(clock), .a({32'd0, dm_ff}), .b({32'd0, dm_ff}), .p(dd_p));

   logic [42:0] tc;
   logic big;
   assign tc = t_p[42:0];
   assign big = (|t_p[63:43]) || (tc >= (43'd6 << 40));

   logic [127:0] sq_p;
   gpj_mul u_mul_sq (.clock(clock), .a({21'd0, tc}), .b({21'd0, tc}), .p(sq_p));

   logic [42:0] tc_ff [6];
   logic [63:0] dd_ff [6];
   logic big_ff [2];
   logic [45:0] t2_ff [4];

   always_ff @(posedge clock) begin
      tc_ff[0] <= tc;
      dd_ff[0] <= dd_p[63:0];
      for (int k = 1; k < 6; k++) begin
         tc_ff[k] <= tc_ff[k-1];
         dd_ff[k] <= dd_ff[k-1];
      end
      big_ff[0] <= big;
      big_ff[1] <= big_ff[0];
      t2_ff[0] <= sq_p[85:40];
      for (int k = 1; k < 4; k++) begin
         t2_ff[k] <= t2_ff[k-1];
      end
   end

   logic [EXP_W-1:0] e;
   gpj_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp (
      .clock(clock), .arg(sq_p[85:65]), .big(big_ff[1]), .e(e)
   );

   logic [127:0] hem_p;
   gpj_mul u_mul_hem (.clock(clock), .a({32'd0, hm}), .b({47'd0, e}), .p(hem_p));

   logic ez_ff [6];
   logic [EXP_W-1:0] e_ff [6];
   logic [32:0] pk_ff [4];

   always_ff @(posedge clock) begin
      ez_ff[0] <= (e == '0);
      e_ff[0] <= e;
      for (int k = 1; k < 6; k++) begin
         ez_ff[k] <= ez_ff[k-1];
         e_ff[k] <= e_ff[k-1];
      end
      pk_ff[0] <= hem_p[48:16];
      for (int k = 1; k < 4; k++) begin
         pk_ff[k] <= pk_ff[k-1];
      end
   end

   logic [63:0] hem;
   assign hem = {15'd0, hem_p[48:0]};

   logic [127:0] x_p, w_p, y_p;
   gpj_mul u_mul_x (.clock(clock), .a({21'd0, tc_ff[5]}), .b(hem), .p(x_p));
   gpj_mul u_mul_w (.clock(clock), .a(dd_ff[5]), .b(hem), .p(w_p));
   gpj_mul u_mul_y (.clock(clock), .a({18'd0, t2_ff[3]}), .b(hem), .p(y_p));

   logic [127:0] c_p, s_p;
   gpj_mul u_mul_c (.clock(clock), .a({12'd0, x_p[91:40]}), .b({32'd0, inv_ff}), .p(c_p));
   gpj_mul u_mul_s (.clock(clock), .a({9'd0, y_p[94:40]}), .b({32'd0, inv_ff}), .p(s_p));

   logic [63:0] w_ff [2];

   always_ff @(posedge clock) begin
      w_ff[0] <= w_p[112:49];
      w_ff[1] <= w_ff[0];
   end

   logic rsp_valid_ff;
   logic [DATA_W-1:0] peak_ff, dh_ff, dc_ff, dw_ff;
   logic last_ff;
   logic [DATA_W-1:0] peak_in, dh_in, dc_in, dw_in;

   always_comb begin
      if (ez_ff[5]) begin
         peak_in = '0;
         dh_in = '0;
         dc_in = '0;
         dw_in = '0;
      end else begin
         peak_in = sat_mag({31'd0, pk_ff[3]}, hneg);
         dh_in = {15'd0, e_ff[5]};
         dc_in = sat_mag({20'd0, c_p[83:40]}, meta_ff[12].dneg != hneg);
         if (mode_ff) begin
            dw_in = sat_mag({17'd0, s_p[86:40]}, hneg);
         end else begin
            dw_in = sat_mag(w_ff[1], !hneg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= meta_ff[12].valid;
      end
   end

   always_ff @(posedge clock) begin
      peak_ff <= peak_in;
      dh_ff <= dh_in;
      dc_ff <= dc_in;
      dw_ff <= dw_in;
      last_ff <= meta_ff[12].last;
   end

   assign busy = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_peak_value = peak_ff;
   assign rsp_d_height = dh_ff;
   assign rsp_d_centre = dc_ff;
   assign rsp_d_width = dw_ff;
   assign rsp_last_out = last_ff;

endmodule

/* src/gpj_mul.sv */
// Two-stage 64 by 64 unsigned multiplier built from four 32 by 32 partial products.
// Depends on nothing but the clock.
`timescale 1ns / 1ps
module gpj_mul (
   input  logic         clock,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic [127:0] p
);

   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] p_ff;

   always_ff @(posedge clock) begin
      p00_ff <= a[31:0] * b[31:0];
      p01_ff <= a[31:0] * b[63:32];
      p10_ff <= a[63:32] * b[31:0];
      p11_ff <= a[63:32] * b[63:32];
      p_ff <= {p11_ff, 64'd0} + (128'(p01_ff) << 32) + (128'(p10_ff) << 32) + 128'(p00_ff);
   end

   assign p = p_ff;

endmodule

/* src/gpj_exp.sv */
// Exponential lookup: exp(-a) for a in unsigned Q5.16 from a constant table with linear
// interpolation. Uses gpj_pkg for the table builder.
`timescale 1ns / 1ps
module gpj_exp
   import gpj_pkg::*;
#(
   parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
   input  logic             clock,
   input  logic [20:0]      arg,
   input  logic             big,
   output logic [EXP_W-1:0] e
);

   localparam int SH = 20 - EXP_TABLE_BITS;
   localparam int TBL = (1 << EXP_TABLE_BITS) + 1;

   logic [EXP_W-1:0] tab [TBL];

   for (genvar k = 0; k < TBL; k++) begin : g_tab
      localparam logic [EXP_W-1:0] ENTRY = exp_entry(k, EXP_TABLE_BITS);
      assign tab[k] = ENTRY;
   end

   logic [EXP_TABLE_BITS:0] idx0, idx1;
   logic [EXP_W-1:0] t0, t1;
   logic [EXP_W-1:0] t0_ff, diff_ff, diff_in;
   logic [SH-1:0] f_ff;
   logic zero_ff;
   logic [EXP_W+SH-1:0] prod;
   logic [EXP_W-1:0] e_ff, e_in;

   assign idx0 = {1'b0, arg[19:SH]};
   assign idx1 = idx0 + 1'b1;
   assign t0 = tab[idx0];
   assign t1 = tab[idx1];
   assign diff_in = (t0 >= t1) ? (t0 - t1) : '0;

   assign prod = diff_ff * f_ff;
   assign e_in = zero_ff ? '0 : (t0_ff - prod[EXP_W+SH-1:SH]);

   always_ff @(posedge clock) begin
      t0_ff <= t0;
      diff_ff <= diff_in;
      f_ff <= arg[SH-1:0];
      zero_ff <= big | arg[20];
      e_ff <= e_in;
   end

   assign e = e_ff;

endmodule

/* src/gpj_checker.sv */
// Port-level checker for the Gaussian peak block, attached to the top level by bind.
// Depends on gpj_pkg and gaussian_peak_with_jacobian.
`timescale 1ns / 1ps
module gpj_checker
   import gpj_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 req_last_in,
   input logic                 rsp_valid,
   input logic [DATA_W-1:0]    rsp_peak_value,
   input logic [DATA_W-1:0]    rsp_d_height,
   input logic [DATA_W-1:0]    rsp_d_centre,
   input logic [DATA_W-1:0]    rsp_d_width,
   input logic                 rsp_last_out
);

   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##14 rsp_valid)
      else $error("sample beat produced no result beat");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 14))
      else $error("result beat without a sample beat");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_out == $past(req_last_in, 14))
      else $error("last flag out of order");

   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_d_height <= 32'h0001_0000)
      else $error("exponential out of range");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_d_height == '0 |->
         rsp_peak_value == '0 && rsp_d_centre == '0 && rsp_d_width == '0)
      else $error("nonzero result with zero exponential");

endmodule

bind gaussian_peak_with_jacobian gpj_checker u_gpj_checker (.*);

/* bench/tb_gaussian_peak_with_jacobian.sv */
// Self-checking bench for gaussian_peak_with_jacobian: writes the registers, drives sample beats
// and compares every result beat against a built-in fixed-point predictor.
// Depends on gpj_pkg and the gaussian_peak_with_jacobian RTL.
`timescale 1ns / 1ps

typedef struct packed {
   bit [31:0] peak_value;
   bit [31:0] d_height;
   bit [31:0] d_centre;
   bit [31:0] d_width;
   bit        last_out;
} peak_beat_type;

class jacobian_checker;
   bit [31:0]     exp_points[0:256];
   bit [31:0]     height;
   bit [31:0]     centre;
   bit [31:0]     inv_sigma;
   bit            by_sigma;
   peak_beat_type pending_beats[$];
   int            mismatches;
   int            beats_checked;
   int            nonzero_beats;

   function new();
      bit [63:0] y;
      bit [63:0] z;
      bit [63:0] term;
      bit [63:0] v;
      longint    acc;
      for (int k = 0; k <= 256; k++) begin
         y = (64'(k) << 34) >> 8;
         z = y >> 5;
         term = 64'd1 << 30;
         acc = 64'sd1 << 30;
         for (int n = 1; n <= 16; n++) begin
            term = ((term * z) >> 30) / 64'(n);
            if (n % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         v = (acc > 0) ? 64'(acc) : 64'd0;
         for (int s = 0; s < 5; s++) begin
            v = (v * v + (64'd1 << 29)) >> 30;
         end
         exp_points[k] = 32'((v + (64'd1 << 13)) >> 14);
      end
      height = 0;
      centre = 0;
      inv_sigma = 32'h0100_0000;
      by_sigma = 0;
   endfunction

   function void set_reg(bit [1:0] idx, bit [31:0] value);
      case (idx)
         gpj_pkg::REG_HEIGHT: height = value;
         gpj_pkg::REG_CENTRE: centre = value;
         gpj_pkg::REG_INV_SIGMA: inv_sigma = value;
         default: by_sigma = value[0];
      endcase
   endfunction

   function bit [63:0] scaled_product(bit [63:0] a, bit [63:0] b, int s);
      bit [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> s;
      if (p[127:64] != 0) begin
         return '1;
      end
      return p[63:0];
   endfunction

   function bit [31:0] clamp(bit [63:0] mag, bit neg);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            mag = 64'h8000_0000;
         end
         return 32'd0 - mag[31:0];
      end
      if (mag > 64'h7FFF_FFFF) begin
         mag = 64'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   function void note_sample(bit [31:0] x, bit last);
      peak_beat_type r;
      longint     d;
      longint     h;
      bit [63:0]  dm;
      bit [63:0]  hm;
      bit [63:0]  t;
      bit [63:0]  a;
      bit [63:0]  e;
      bit [63:0]  t0;
      bit [63:0]  t1;
      bit [63:0]  diff;
      bit [63:0]  hem;
      bit [63:0]  c;
      bit [63:0]  w;
      bit [63:0]  dd;
      d = longint'($signed(x)) - longint'($signed(centre));
      h = longint'($signed(height));
      dm = (d < 0) ? 64'(-d) : 64'(d);
      hm = (h < 0) ? 64'(-h) : 64'(h);
      t = dm * 64'(inv_sigma);
      e = 0;
      r = '{0, 0, 0, 0, last};
      if (t < (64'd6 << 40)) begin
         a = scaled_product(t, t, 40) >> 25;
         if (a < (64'd16 << 16)) begin
            t0 = exp_points[a >> 12];
            t1 = exp_points[(a >> 12) + 1];
            diff = (t0 >= t1) ? t0 - t1 : 64'd0;
            e = t0 - ((diff * (a & 64'hFFF)) >> 12);
         end
      end
      if (e != 0) begin
         nonzero_beats++;
         hem = hm * e;
         r.peak_value = clamp(hem >> 16, h < 0);
         r.d_height = e[31:0];
         c = scaled_product(scaled_product(t, hem, 40), 64'(inv_sigma), 40);
         r.d_centre = clamp(c, c != 0 && ((d < 0) != (h < 0)));
         if (!by_sigma) begin
            dd = dm * dm;
            w = scaled_product(dd, hem, 49);
            r.d_width = clamp(w, w != 0 && !(h < 0));
         end else begin
            w = scaled_product(scaled_product(scaled_product(t, t, 40), hem, 40),
                               64'(inv_sigma), 40);
            r.d_width = clamp(w, w != 0 && (h < 0));
         end
      end
      pending_beats.push_back(r);
   endfunction

   function void check_beat(peak_beat_type got);
      peak_beat_type want;
      beats_checked++;
      if (pending_beats.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected result beat: %h %h %h %h %b", got.peak_value,
                     got.d_height, got.d_centre, got.d_width, got.last_out);
         end
         return;
      end
      want = pending_beats.pop_front();
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("result mismatch: expected %h %h %h %h %b, got %h %h %h %h %b",
                     want.peak_value, want.d_height, want.d_centre, want.d_width,
                     want.last_out, got.peak_value, got.d_height, got.d_centre,
                     got.d_width, got.last_out);
         end
      end
   endfunction
endclass

module tb_gaussian_peak_with_jacobian;
   import gpj_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [DATA_W-1:0]    req_x_sample;
   logic                 req_last_in;
   logic                 rsp_valid;
   logic [DATA_W-1:0]    rsp_peak_value;
   logic [DATA_W-1:0]    rsp_d_height;
   logic [DATA_W-1:0]    rsp_d_centre;
   logic [DATA_W-1:0]    rsp_d_width;
   logic                 rsp_last_out;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   jacobian_checker ledger;
   int              idle_pct;
   int              stall_cycles;
   int              samples_sent;
   int              phases_run;

   gaussian_peak_with_jacobian dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            ledger.check_beat('{rsp_peak_value, rsp_d_height, rsp_d_centre, rsp_d_width,
                                rsp_last_out});
         end
         if (rsp_valid || (start && !busy)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= 5000) begin
               $display("tb_gaussian_peak_with_jacobian: errors");
               $finish;
            end
         end
      end
   end

   task automatic send_sample(bit [31:0] x, bit last);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_x_sample <= x;
      req_last_in <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      ledger.note_sample(x, last);
      samples_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (ledger.pending_beats.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(bit [1:0] idx, bit [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      ledger.set_reg(idx, value);
   endtask

   task automatic configure(bit [31:0] h, bit [31:0] c, bit [31:0] inv, bit mode);
      drain();
      write_reg(REG_HEIGHT, h);
      write_reg(REG_CENTRE, c);
      write_reg(REG_INV_SIGMA, inv);
      write_reg(REG_MODE, {31'(0), mode});
      csr_we <= 1'b0;
      phases_run++;
   endtask

   function automatic bit [31:0] near_peak(bit [31:0] c, bit [31:0] inv);
      bit [63:0] span;
      longint    off;
      span = (inv == 0) ? 64'hFFFF_FFFF : ((64'd6 << 40) / 64'(inv)) + 1;
      if (span > 64'hFFFF_FFFF) begin
         span = 64'hFFFF_FFFF;
      end
      off = longint'({$urandom, $urandom} % span);
      if ($urandom_range(1)) begin
         off = -off;
      end
      return c + 32'(off);
   endfunction

   initial begin
      bit [31:0] h;
      bit [31:0] c;
      bit [31:0] inv;
      ledger = new();
      reset = 1'b1;
      start = 1'b0;
      req_x_sample = '0;
      req_last_in = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_pct = 21;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0001_0000, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      configure(32'h7FFF_FFFF, 32'h0000_0000, 32'h0100_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0002_0000, 1'b0);
      send_sample(32'hFFFE_0000, 1'b0);
      send_sample(32'h0005_A000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b1);
      configure(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0001_8000, 1'b1);
      configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h7FFF_FFFE, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      configure(32'h0123_4567, 32'hFFFF_0000, 32'h0040_0000, 1'b1);
      send_sample(32'hFFFF_0000, 1'b0);
      send_sample(32'h0003_0000, 1'b0);
      send_sample(32'hFFFA_0000, 1'b0);
      send_sample(32'h0013_0000, 1'b1);

      for (int p = 0; p < 12; p++) begin
         if (p == 4) begin
            idle_pct = 55;
         end else if (p == 8) begin
            idle_pct = 0;
         end
         case ($urandom_range(4))
            0: inv = 32'h0000_0000;
            1: inv = 32'hFFFF_FFFF;
            2: inv = $urandom;
            default: inv = $urandom_range(32'h0001_0000, 32'h1000_0000);
         endcase
         h = $urandom;
         c = $urandom;
         if (p < 2) begin
            h = p ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
         configure(h, c, inv, 1'(p % 2));
         for (int n = 0; n < 106; n++) begin
            if ($urandom_range(99) < 80) begin
               send_sample(near_peak(c, inv), 1'($urandom_range(1)));
            end else begin
               send_sample($urandom, 1'($urandom_range(1)));
            end
         end
      end

      drain();
      if (ledger.pending_beats.size() != 0) begin
         ledger.mismatches++;
      end
      $display("Covered %0d samples over %0d register settings; %0d result beats checked.",
               samples_sent, phases_run, ledger.beats_checked);
      $display("%0d beats had a nonzero exponential; %0d mismatches.",
               ledger.nonzero_beats, ledger.mismatches);
      if (ledger.mismatches == 0) begin
         $display("tb_gaussian_peak_with_jacobian: clean");
      end else begin
         $display("tb_gaussian_peak_with_jacobian: errors");
      end
      $finish;
   end

endmodule
